/* hdl/hcr_pkg.sv */
`default_nettype none

package hcr_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_HUE_SPEED  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SATURATION = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BRIGHTNESS = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GLOW_GAIN  = 3'd3;
  localparam int unsigned CfgDataW = 32;

  // Reset values
  localparam logic signed [15:0] HUE_SPEED_RST  = 16'sd256;
  localparam logic [16:0]        ONE_Q16        = 17'd65536;
  localparam logic [15:0]        GLOW_GAIN_RST  = 16'd4096;

  // Hue reduction constants.
  // Bias is a multiple of 360 that makes any whole-degree hue non-negative.
  localparam logic [26:0] HUE_BIAS   = 27'd16777440;  // 360 * 46604
  localparam logic [23:0] RECIP_45   = 24'd11930465;  // ceil(2^29 / 45)
  localparam int unsigned RECIP_45_SH = 29;
  localparam logic [16:0] SECT_BASE  = 17'd1092;      // 16380 / 15
  localparam logic [17:0] RECIP_15   = 18'd17477;     // ceil(2^18 / 15)
  localparam int unsigned RECIP_15_SH = 18;
  localparam logic [14:0] Z_LIMIT    = 15'd16620;

  localparam logic [2:0] SECTOR_MAX = 3'd5;

  typedef struct packed {
    logic [31:0] anim_time;
    logic [9:0]  hue_offset;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } out_item_t;

  // Hue stage result handed to the color stages
  typedef struct packed {
    logic        valid;
    logic [2:0]  sector;
    logic [15:0] frac;
  } hue_t;

  // Per-item-constant color terms derived from configuration
  typedef struct packed {
    logic [16:0] chroma;
    logic [16:0] m_level;
    logic [15:0] glow;
  } color_cfg_t;

  // 60-degree sector of a hue in whole degrees (0..359)
  function automatic logic [2:0] sector_of(input logic [8:0] deg);
    logic [2:0] s;
    if (deg >= 9'd300)      s = 3'd5;
    else if (deg >= 9'd240) s = 3'd4;
    else if (deg >= 9'd180) s = 3'd3;
    else if (deg >= 9'd120) s = 3'd2;
    else if (deg >= 9'd60)  s = 3'd1;
    else                    s = 3'd0;
    return s;
  endfunction

  // Start of a sector in degrees
  function automatic logic [8:0] sector_start(input logic [2:0] s);
    logic [8:0] d;
    unique case (s)
      3'd0:    d = 9'd0;
      3'd1:    d = 9'd60;
      3'd2:    d = 9'd120;
      3'd3:    d = 9'd180;
      3'd4:    d = 9'd240;
      default: d = 9'd300;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

/* hdl/hue_cycle_hsv_to_rgb_top.sv */
// Hue-cycling HSV to RGB color source.
// Input channel (in_valid_i / in_stall_o / in_item_i): one item carries an
// animation time (Q16.16 s) and a hue offset (whole degrees). Each item gives
// one RGB item on the output channel (out_valid_o / out_stall_i / out_item_o).
// Hue = time * hue_speed + offset, floor mod 360; HSV to RGB with configured
// saturation and brightness; each channel times glow gain, clamped at 1.0.
// Throughput: one item per cycle while the output is not stalled, set by the
// seven-stage pipeline with a single shared advance enable. Each item passes
// S1 to S7 in order; out_valid_o is the valid bit of the last stage, S7.
// Stall: while out_valid_o is high and out_stall_i is high the whole pipeline
// holds, and in_stall_o is raised; bubbles keep moving when the output is empty.
// Configuration (cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i): always
// ready; index 0 hue speed, 1 saturation, 2 brightness, 3 glow gain; others
// are ignored. Write only while no item is in flight.
// Reset (rst_ni low, async): pipeline empties, registers take their reset
// values: speed 1.0 deg/s, saturation 1.0, brightness 1.0, glow 1.0.
`default_nettype none

module hue_cycle_hsv_to_rgb_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire hcr_pkg::in_item_t                in_item_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output hcr_pkg::out_item_t                    out_item_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [hcr_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [hcr_pkg::CfgDataW-1:0]     cfg_data_i
);

  // Configuration registers
  logic signed [15:0] hue_speed_q;
  logic [16:0]        sat_q;
  logic [16:0]        bri_q;
  logic [15:0]        glow_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_speed_q <= hcr_pkg::HUE_SPEED_RST;
      sat_q       <= hcr_pkg::ONE_Q16;
      bri_q       <= hcr_pkg::ONE_Q16;
      glow_q      <= hcr_pkg::GLOW_GAIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        hcr_pkg::CFG_HUE_SPEED:  hue_speed_q <= $signed(cfg_data_i[15:0]);
        hcr_pkg::CFG_SATURATION: sat_q       <= cfg_data_i[16:0];
        hcr_pkg::CFG_BRIGHTNESS: bri_q       <= cfg_data_i[16:0];
        hcr_pkg::CFG_GLOW_GAIN:  glow_q      <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Chroma and m depend on configuration only; registered once here.
  logic [16:0] s_sat, v_sat;
  logic [33:0] cv_prod;
  logic [16:0] chroma_d, chroma_q, m_d, m_q;

  assign s_sat    = (sat_q > hcr_pkg::ONE_Q16) ? hcr_pkg::ONE_Q16 : sat_q;
  assign v_sat    = (bri_q > hcr_pkg::ONE_Q16) ? hcr_pkg::ONE_Q16 : bri_q;
  assign cv_prod  = 34'(v_sat) * 34'(s_sat);
  assign chroma_d = cv_prod[32:16];
  assign m_d      = v_sat - chroma_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chroma_q <= hcr_pkg::ONE_Q16;
      m_q      <= '0;
    end else begin
      chroma_q <= chroma_d;
      m_q      <= m_d;
    end
  end

  // One advance enable for all stages: hold only when a result waits.
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  hcr_pkg::hue_t       hue;
  hcr_pkg::color_cfg_t color_cfg;

  assign color_cfg.chroma  = chroma_q;
  assign color_cfg.m_level = m_q;
  assign color_cfg.glow    = glow_q;

  hcr_hue u_hue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_valid_i),
    .item_i      (in_item_i),
    .hue_speed_i (hue_speed_q),
    .hue_o       (hue)
  );

  hcr_color u_color (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .hue_i   (hue),
    .cfg_i   (color_cfg),
    .valid_o (out_valid_o),
    .item_o  (out_item_o)
  );

endmodule

`default_nettype wire

/* hdl/hcr_hue.sv */
`default_nettype none

// Hue path: product, floor mod 360, sector and in-sector fraction. Four stages.
module hcr_hue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire hcr_pkg::in_item_t   item_i,
  input  wire logic signed [15:0]  hue_speed_i,
  output hcr_pkg::hue_t            hue_o
);

  // S1: h = t * speed + offset << 24 (Q.24 degrees)
  logic               s1_valid_q;
  logic signed [49:0] s1_h_q, s1_h_d;
  logic signed [48:0] s1_prod;

  assign s1_prod = $signed({1'b0, item_i.anim_time}) * hue_speed_i;
  assign s1_h_d  = 50'(s1_prod) + $signed({16'd0, item_i.hue_offset, 24'd0});

  // S2: biased whole degrees, quotient by 45 via reciprocal
  localparam logic signed [26:0] HUE_BIAS_S = $signed(hcr_pkg::HUE_BIAS);

  logic               s2_valid_q;
  logic signed [26:0] s2_u_full;
  logic [24:0]        s2_u;
  logic [21:0]        s2_v;
  logic [45:0]        s2_prod;
  logic [16:0]        s2_q_q;
  logic [21:0]        s2_v_q;
  logic [2:0]         s2_lo_q;
  logic [13:0]        s2_l_q;

  assign s2_u_full = 27'($signed(s1_h_q[49:24])) + HUE_BIAS_S;
  assign s2_u      = s2_u_full[24:0];
  assign s2_v      = s2_u[24:3];
  assign s2_prod   = s2_v * hcr_pkg::RECIP_45;

  // S3: remainder, sector, fraction operands
  logic        s3_valid_q;
  logic [22:0] s3_q45;
  logic [21:0] s3_r_full;
  logic [8:0]  s3_deg;
  logic [2:0]  s3_sector;
  logic [8:0]  s3_in_sect;
  logic [5:0]  s3_hm;
  logic [2:0]  s3_sector_q;
  logic [14:0] s3_z_q;
  logic [16:0] s3_base_q;

  assign s3_q45     = 23'(s2_q_q) * 23'd45;
  assign s3_r_full  = s2_v_q - s3_q45[21:0];
  assign s3_deg     = {s3_r_full[5:0], s2_lo_q};
  assign s3_sector  = hcr_pkg::sector_of(s3_deg);
  assign s3_in_sect = s3_deg - hcr_pkg::sector_start(s3_sector);
  assign s3_hm      = s3_in_sect[5:0];

  // S4: frac = hm * 1092 + (4 * hm + l) / 15
  logic        s4_valid_q;
  logic [32:0] s4_prod;
  logic [16:0] s4_frac_full;
  logic [2:0]  s4_sector_q;
  logic [15:0] s4_frac_q;

  assign s4_prod      = 33'(s3_z_q) * 33'(hcr_pkg::RECIP_15);
  assign s4_frac_full = s3_base_q + 17'(s4_prod[32:hcr_pkg::RECIP_15_SH]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_h_q      <= s1_h_d;
      s2_q_q      <= s2_prod[45:hcr_pkg::RECIP_45_SH];
      s2_v_q      <= s2_v;
      s2_lo_q     <= s2_u[2:0];
      s2_l_q      <= s1_h_q[23:10];
      s3_sector_q <= s3_sector;
      s3_z_q      <= {7'd0, s3_hm, 2'b00} + {1'b0, s2_l_q};
      s3_base_q   <= 17'(s3_hm) * hcr_pkg::SECT_BASE;
      s4_sector_q <= s3_sector_q;
      s4_frac_q   <= s4_frac_full[15:0];
    end
  end

  assign hue_o.valid  = s4_valid_q;
  assign hue_o.sector = s4_sector_q;
  assign hue_o.frac   = s4_frac_q;

  a_quot_not_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (s3_r_full < 22'd45))
    else $error("quotient by 45 overshoots");

  a_z_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> (s3_z_q < hcr_pkg::Z_LIMIT))
    else $error("fraction operand outside reciprocal range");

  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_valid_q |-> (s4_sector_q <= hcr_pkg::SECTOR_MAX))
    else $error("sector out of range");

endmodule

`default_nettype wire

/* hdl/hcr_color.sv */
`default_nettype none

// Color path: side value, sector table plus m, glow gain, clamp, 8-bit scale.
module hcr_color (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire hcr_pkg::hue_t        hue_i,
  input  wire hcr_pkg::color_cfg_t  cfg_i,
  output logic                      valid_o,
  output hcr_pkg::out_item_t        item_o
);

  // S5: x = c * f (even sector) or c * (1 - f) (odd sector)
  logic        s5_valid_q;
  logic [16:0] s5_op;
  logic [33:0] s5_prod;
  logic [16:0] s5_x_q;
  logic [2:0]  s5_sector_q;

  assign s5_op   = hue_i.sector[0] ? (hcr_pkg::ONE_Q16 - {1'b0, hue_i.frac})
                                   : {1'b0, hue_i.frac};
  assign s5_prod = 34'(cfg_i.chroma) * 34'(s5_op);

  // S6: channels plus m, times glow
  logic        s6_valid_q;
  logic [16:0] r_c, g_c, b_c;
  logic [32:0] s6_r_q, s6_g_q, s6_b_q;

  always_comb begin
    r_c = '0;
    g_c = '0;
    b_c = '0;
    unique case (s5_sector_q)
      3'd0: begin r_c = cfg_i.chroma; g_c = s5_x_q;       end
      3'd1: begin r_c = s5_x_q;       g_c = cfg_i.chroma; end
      3'd2: begin g_c = cfg_i.chroma; b_c = s5_x_q;       end
      3'd3: begin g_c = s5_x_q;       b_c = cfg_i.chroma; end
      3'd4: begin r_c = s5_x_q;       b_c = cfg_i.chroma; end
      default: begin r_c = cfg_i.chroma; b_c = s5_x_q;    end
    endcase
  end

  function automatic logic [32:0] glow_mul(input logic [16:0] ch, input logic [16:0] m,
                                           input logic [15:0] gain);
    logic [16:0] sum;
    sum = ch + m;
    return 33'(sum) * 33'(gain);
  endfunction

  // S7: >> 12, clamp at 1.0, scale by 255 / 65536
  function automatic logic [7:0] to_byte(input logic [32:0] p);
    logic [20:0] g;
    logic [16:0] gc;
    logic [24:0] s;
    g  = p[32:12];
    gc = (g > 21'(hcr_pkg::ONE_Q16)) ? hcr_pkg::ONE_Q16 : g[16:0];
    s  = {gc, 8'd0} - 25'(gc);
    return s[23:16];
  endfunction

  logic s7_valid_q;
  hcr_pkg::out_item_t s7_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
      s7_valid_q <= 1'b0;
    end else if (en_i) begin
      s5_valid_q <= hue_i.valid;
      s6_valid_q <= s5_valid_q;
      s7_valid_q <= s6_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_x_q      <= s5_prod[32:16];
      s5_sector_q <= hue_i.sector;
      s6_r_q      <= glow_mul(r_c, cfg_i.m_level, cfg_i.glow);
      s6_g_q      <= glow_mul(g_c, cfg_i.m_level, cfg_i.glow);
      s6_b_q      <= glow_mul(b_c, cfg_i.m_level, cfg_i.glow);
      s7_item_q.red_out   <= to_byte(s6_r_q);
      s7_item_q.green_out <= to_byte(s6_g_q);
      s7_item_q.blue_out  <= to_byte(s6_b_q);
    end
  end

  assign valid_o = s7_valid_q;
  assign item_o  = s7_item_q;

endmodule

`default_nettype wire

/* dv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned RESET_CYCLES   = 12;
  localparam int unsigned PIPE_LATENCY   = 7;     // input accept to earliest output accept
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
  localparam int unsigned RAND_PHASES    = 10;
  localparam int unsigned PHASE_ITEMS    = 68;

  // Hue in Q.24 degrees
  localparam longint HUE_SECTOR = 60 * 2**24;
  localparam longint HUE_CIRCLE = 6 * HUE_SECTOR;
  localparam longint unsigned CHAN_FULL = 255;

  // Indexes past the last register are decoded as no-ops
  localparam logic [hcr_pkg::CfgIdxW-1:0] CFG_IDX_LAST = '1;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  hcr_pkg::in_item_t  in_item_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  hcr_pkg::out_item_t out_item_o;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [hcr_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [hcr_pkg::CfgDataW-1:0] cfg_data_i  = '0;

  hue_cycle_hsv_to_rgb_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow copy of the configuration registers, updated on each write handshake.
  // Items are only sent while these are stable, so the prediction at accept
  // time sees exactly what the pipeline sees.
  // ---------------------------------------------------------------------------
  logic signed [15:0] speed_cfg  = hcr_pkg::HUE_SPEED_RST;
  logic [16:0]        sat_cfg    = hcr_pkg::ONE_Q16;
  logic [16:0]        bright_cfg = hcr_pkg::ONE_Q16;
  logic [15:0]        glow_cfg   = hcr_pkg::GLOW_GAIN_RST;

  hcr_pkg::in_item_t  item_feed_q[$];     // items waiting for the driver
  hcr_pkg::out_item_t color_expect_q[$];  // predicted colors, oldest first

  int unsigned items_sent    = 0;
  int unsigned colors_seen   = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned reg_writes    = 0;
  int unsigned settings_cnt  = 1;
  int unsigned quiet_cycles  = 0;

  int unsigned send_gap = 0, send_steady = 0;
  int unsigned recv_gap = 0, recv_steady = 0;

  // Idle length: mostly none or short, a few long; now and then a steady
  // stretch of zeros so back-to-back traffic is exercised too.
  function automatic int unsigned idle_len(inout int unsigned steady_left);
    int unsigned roll;
    if (steady_left != 0) begin
      steady_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      steady_left = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Channel through glow gain, clamp at 1.0, scale to a byte
  function automatic logic [7:0] glow_to_byte(longint unsigned level);
    longint unsigned lit;
    lit = (level * glow_cfg) >> 12;
    if (lit > hcr_pkg::ONE_Q16) lit = hcr_pkg::ONE_Q16;
    return 8'((lit * CHAN_FULL) >> 16);
  endfunction

  // Expected color for one item under the current shadow settings
  function automatic hcr_pkg::out_item_t predict_color(hcr_pkg::in_item_t item);
    longint t, spd, off, hue, sector, rem;
    longint unsigned frac, sat, val, chroma, side, floor_lvl, r, g, b;
    hcr_pkg::out_item_t color;
    t   = item.anim_time;   // zero-extended
    spd = speed_cfg;        // sign-extended
    off = item.hue_offset;
    hue = t * spd + (off <<< 24);
    // floor modulo: negative hue wraps back into [0, 360)
    hue = hue % HUE_CIRCLE;
    if (hue < 0) hue += HUE_CIRCLE;
    sector = hue / HUE_SECTOR;
    rem    = hue % HUE_SECTOR;
    frac   = (rem <<< 16) / HUE_SECTOR;

    // levels above one saturate at 1.0
    sat = (sat_cfg > hcr_pkg::ONE_Q16) ? hcr_pkg::ONE_Q16 : sat_cfg;
    val = (bright_cfg > hcr_pkg::ONE_Q16) ? hcr_pkg::ONE_Q16 : bright_cfg;
    chroma    = (val * sat) >> 16;
    floor_lvl = val - chroma;
    if (sector[0] == 1'b0) side = (chroma * frac) >> 16;
    else                   side = (chroma * (hcr_pkg::ONE_Q16 - frac)) >> 16;

    case (sector)
      0: begin r = chroma; g = side;   b = 0;      end
      1: begin r = side;   g = chroma; b = 0;      end
      2: begin r = 0;      g = chroma; b = side;   end
      3: begin r = 0;      g = side;   b = chroma; end
      4: begin r = side;   g = 0;      b = chroma; end
      default: begin r = chroma; g = 0; b = side;  end
    endcase

    color.red_out   = glow_to_byte(r + floor_lvl);
    color.green_out = glow_to_byte(g + floor_lvl);
    color.blue_out  = glow_to_byte(b + floor_lvl);
    return color;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: predict on every accepted item, then load the next one from the
  // feed queue once the current one is gone. Valid is never withdrawn while
  // an item is stalled, and gaps are inserted between items at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        color_expect_q.push_back(predict_color(in_item_i));
        items_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (item_feed_q.size() != 0) begin
          in_item_i  <= item_feed_q.pop_front();
          in_valid_i <= 1'b1;
          send_gap = idle_len(send_steady);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted color with the oldest prediction; stall
  // the output at random, independent of whether anything is coming.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    hcr_pkg::out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        colors_seen++;
        if (color_expect_q.size() == 0) begin
          $display("%0t: unexpected color, expected none, got %h", $time, out_item_o);
          mismatch_cnt++;
        end else begin
          want = color_expect_q.pop_front();
          check_field("red_out",   want.red_out,   out_item_o.red_out);
          check_field("green_out", want.green_out, out_item_o.green_out);
          check_field("blue_out",  want.blue_out,  out_item_o.blue_out);
        end
      end
      if (recv_gap != 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        recv_gap = idle_len(recv_steady);
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d colors still owed", $time,
               WATCHDOG_LIMIT, color_expect_q.size());
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold the sender off until every owed color is back, then let the
  // pipeline settle for its latency. Checked at the falling edge so the
  // driver's updates from the last rising edge have landed.
  task automatic drain_pipe();
    while (item_feed_q.size() != 0 || in_valid_i || color_expect_q.size() != 0)
      @(negedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  // One register write; the shadow copy follows at the handshake
  task automatic write_reg(input logic [hcr_pkg::CfgIdxW-1:0] idx,
                           input logic [hcr_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      hcr_pkg::CFG_HUE_SPEED:  speed_cfg  = data[15:0];
      hcr_pkg::CFG_SATURATION: sat_cfg    = data[16:0];
      hcr_pkg::CFG_BRIGHTNESS: bright_cfg = data[16:0];
      hcr_pkg::CFG_GLOW_GAIN:  glow_cfg   = data[15:0];
      default: ;  // unmapped index, ignored by the block
    endcase
    reg_writes++;
  endtask

  // Register data with random junk above the register width
  function automatic logic [hcr_pkg::CfgDataW-1:0] pad_data(input logic [16:0] value,
                                                           input int w);
    logic [hcr_pkg::CfgDataW-1:0] data;
    data = $urandom();
    for (int i = 0; i < w; i++) data[i] = value[i];
    return data;
  endfunction

  function automatic logic [16:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return hcr_pkg::ONE_Q16;
      2:       return 17'($urandom_range(int'(hcr_pkg::ONE_Q16) + 1, 17'h1FFFF));  // above one
      3:       return 17'($urandom_range(60000, int'(hcr_pkg::ONE_Q16)));
      default: return 17'($urandom_range(0, int'(hcr_pkg::ONE_Q16)));
    endcase
  endfunction

  task automatic randomize_settings();
    logic [15:0] speed, glow;
    case ($urandom_range(0, 6))
      0:       speed = 16'h8000;  // most negative
      1:       speed = 16'h7FFF;
      2:       speed = '0;
      3:       speed = 16'hFF00;  // -1 deg/s
      default: speed = 16'($urandom());
    endcase
    case ($urandom_range(0, 5))
      0:       glow = '0;
      1:       glow = hcr_pkg::GLOW_GAIN_RST;
      2:       glow = 16'hFFFF;
      3:       glow = 16'($urandom_range(2048, 8192));
      default: glow = 16'($urandom());
    endcase
    write_reg(hcr_pkg::CFG_HUE_SPEED,  pad_data(17'(speed), 16));
    write_reg(hcr_pkg::CFG_SATURATION, pad_data(pick_level(), 17));
    write_reg(hcr_pkg::CFG_BRIGHTNESS, pad_data(pick_level(), 17));
    write_reg(hcr_pkg::CFG_GLOW_GAIN,  pad_data(17'(glow), 16));
    if ($urandom_range(0, 2) == 0)
      write_reg(hcr_pkg::CfgIdxW'($urandom_range(int'(hcr_pkg::CFG_GLOW_GAIN) + 1,
                                                 int'(CFG_IDX_LAST))),
                $urandom());
    settings_cnt++;
  endtask

  function automatic hcr_pkg::in_item_t mk_item(input logic [31:0] t, input logic [9:0] off);
    hcr_pkg::in_item_t it;
    it.anim_time  = t;
    it.hue_offset = off;
    return it;
  endfunction

  // Random items: plain random, short animation times, the top of the time
  // range, and offsets sitting on sector edges.
  function automatic hcr_pkg::in_item_t rand_item();
    hcr_pkg::in_item_t it;
    it.anim_time  = $urandom();
    it.hue_offset = 10'($urandom());
    case ($urandom_range(0, 5))
      0: it.anim_time = $urandom_range(0, 32'h0168_0000);  // under 360 s
      1: it.anim_time = it.anim_time | 32'hFFF0_0000;
      2: it.hue_offset = 10'(60 * $urandom_range(0, 17) + $urandom_range(0, 2) - 1);
      3: it.anim_time[31:16] = '0;                          // under one second
      default: ;
    endcase
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings (1 deg/s, full saturation and brightness, unit glow):
    // the pure hue wheel, sector edges, large offsets, time extremes.
    item_feed_q.push_back(mk_item(32'h0000_0000, 10'd0));
    item_feed_q.push_back(mk_item(32'h0000_0000, 10'd1023));
    item_feed_q.push_back(mk_item(32'h0000_0000, 10'd60));
    item_feed_q.push_back(mk_item(32'h0000_0000, 10'd120));
    item_feed_q.push_back(mk_item(32'h0000_0000, 10'd180));
    item_feed_q.push_back(mk_item(32'h0000_0000, 10'd240));
    item_feed_q.push_back(mk_item(32'h0000_0000, 10'd300));
    item_feed_q.push_back(mk_item(32'h0000_0000, 10'd359));
    item_feed_q.push_back(mk_item(32'h0000_0000, 10'd360));
    item_feed_q.push_back(mk_item(32'h0000_0000, 10'd720));
    item_feed_q.push_back(mk_item(32'h0000_FFFF, 10'd59));
    item_feed_q.push_back(mk_item(32'h001E_0000, 10'd0));
    item_feed_q.push_back(mk_item(32'h8000_0000, 10'd0));
    item_feed_q.push_back(mk_item(32'hFFFF_FFFF, 10'd0));
    drain_pipe();

    // Most negative speed, saturation and brightness above one, max glow,
    // plus a write to an unmapped index that must not disturb anything.
    write_reg(hcr_pkg::CFG_HUE_SPEED,  32'h0000_8000);
    write_reg(hcr_pkg::CFG_SATURATION, 32'h0001_FFFF);
    write_reg(hcr_pkg::CFG_BRIGHTNESS, 32'hFFFF_0001);
    write_reg(hcr_pkg::CFG_GLOW_GAIN,  32'h0000_FFFF);
    write_reg(CFG_IDX_LAST,            32'hFFFF_FFFF);
    settings_cnt++;
    item_feed_q.push_back(mk_item(32'h0000_0000, 10'd0));
    item_feed_q.push_back(mk_item(32'h0000_0001, 10'd0));   // tiny negative hue
    item_feed_q.push_back(mk_item(32'h0001_0000, 10'd0));
    item_feed_q.push_back(mk_item(32'h0123_4567, 10'd200));
    item_feed_q.push_back(mk_item(32'hFFFF_FFFF, 10'd1023));
    drain_pipe();

    // Max positive speed, grey/black corner: zero saturation, brightness, glow
    write_reg(hcr_pkg::CFG_HUE_SPEED,  32'h0000_7FFF);
    write_reg(hcr_pkg::CFG_SATURATION, 32'h0000_0000);
    write_reg(hcr_pkg::CFG_BRIGHTNESS, 32'h0000_0000);
    write_reg(hcr_pkg::CFG_GLOW_GAIN,  32'h0000_0000);
    settings_cnt++;
    item_feed_q.push_back(mk_item(32'hFFFF_FFFF, 10'd1023));
    item_feed_q.push_back(mk_item(32'h0000_0000, 10'd0));
    item_feed_q.push_back(mk_item(32'h5A5A_A5A5, 10'd512));

    // Random settings per phase; each phase drains fully before the next
    // write, which also gives the required sender pause.
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_pipe();
      randomize_settings();
      repeat (PHASE_ITEMS) item_feed_q.push_back(rand_item());
    end
    drain_pipe();

    $display("Run covered %0d items and %0d checked colors over %0d settings (%0d reg writes).",
             items_sent, colors_seen, settings_cnt, reg_writes);
    $display("Mismatches: %0d", mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/hcr_pkg.sv
hdl/hcr_hue.sv
hdl/hcr_color.sv
hdl/hue_cycle_hsv_to_rgb_top.sv
dv/testbench.sv
